// File: rtl/matrix_multiply_unit_macros.svh
// Assertion macros for the checker file of the matrix multiply unit.
`ifndef MATRIX_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX_MULTIPLY_UNIT_MACROS_SVH

// Next-cycle implication, ignored while reset is high.
`define MMU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define MMU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/mmu_pkg.sv
// Shared types, constants and helper functions of the matrix multiply unit.
`timescale 1ns / 1ps
`default_nettype none

package mmu_pkg;

  // largest supported matrix dimension
  localparam int MAX_DIM_DEFAULT = 8;

  // field widths fixed by the interface
  localparam int ELEM_W   = 32;
  localparam int DIM_W    = 4;
  localparam int IDX_OUT_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = 2 * ELEM_W;
  // room for the sum of up to eight full-scale products
  localparam int ACC_W    = PROD_W + 3;
  localparam int FRAC_W   = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM       = 2'd3;

  typedef enum logic [1:0] {
    ST_LOAD_A,
    ST_LOAD_B,
    ST_COMPUTE
  } state_t;

  // per-step tag carried down the multiply-accumulate pipeline
  typedef struct packed {
    logic                 first;
    logic                 last;
    logic                 run_end;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
  } step_t;

  // zero reads as one, anything above the maximum reads as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] d;
    begin
      d = v;
      if (d == '0) d = {{(DIM_W-1){1'b0}}, 1'b1};
      if (d > max_dim) d = max_dim;
      return d;
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/mmu_mem.sv
// Single-port-write, single-port-read element store with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module mmu_mem #(
  parameter int DEPTH = mmu_pkg::MAX_DIM_DEFAULT * mmu_pkg::MAX_DIM_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [mmu_pkg::ELEM_W-1:0]  wdata,
  input  wire logic                        re,
  input  wire logic [AW-1:0]               raddr,
  output logic      [mmu_pkg::ELEM_W-1:0]  rdata
);

  logic [mmu_pkg::ELEM_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/mmu_mac.sv
// Shared multiply-accumulate pipeline with saturation and the output register.
`timescale 1ns / 1ps
`default_nettype none

module mmu_mac (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // step issued this cycle; its operands arrive from the stores next cycle
  input  wire logic                          issue,
  input  wire mmu_pkg::step_t                issue_tag,
  input  wire logic [mmu_pkg::ELEM_W-1:0]    a_data,
  input  wire logic [mmu_pkg::ELEM_W-1:0]    b_data,
  output logic                               stall,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [mmu_pkg::ELEM_W-1:0]  product_value,
  output logic [mmu_pkg::IDX_OUT_W-1:0]      product_row,
  output logic [mmu_pkg::IDX_OUT_W-1:0]      product_col,
  output logic                               saturated,
  output logic                               last_of_run
);

  localparam int SH_W = mmu_pkg::ACC_W - mmu_pkg::FRAC_W;

  logic                              v1, v2, v3;
  mmu_pkg::step_t                    t1, t2, t3;
  logic signed [mmu_pkg::PROD_W-1:0] prod;
  logic signed [mmu_pkg::ACC_W-1:0]  acc;
  logic signed [mmu_pkg::ACC_W-1:0]  acc_next;
  logic signed [SH_W-1:0]            shifted;
  logic                              ovf;
  logic [mmu_pkg::ELEM_W-1:0]        sat_value;
  logic                              load_out;

  // whole pipeline freezes while a finished beat waits
  assign stall    = out_valid && !out_ready;
  assign load_out = v3 && t3.last && !stall;

  // stage 1: operands in the store read registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (!stall) begin
      v1 <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) t1 <= issue_tag;
  end

  // stage 2: product register
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (!stall) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      t2   <= t1;
      prod <= $signed(a_data) * $signed(b_data);
    end
  end

  // stage 3: accumulator, restarted on the first step of each dot product
  always_comb begin
    acc_next = (t2.first ? '0 : acc) + mmu_pkg::ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (!stall) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && v2) begin
      acc <= acc_next;
      t3  <= t2;
    end
  end

  // drop fraction bits (floor) and saturate to 32 bits
  always_comb begin
    shifted = SH_W'(acc >>> mmu_pkg::FRAC_W);
    ovf     = (shifted[SH_W-1:mmu_pkg::ELEM_W-1] != '0) &&
              (shifted[SH_W-1:mmu_pkg::ELEM_W-1] != '1);
    if (!ovf) begin
      sat_value = shifted[mmu_pkg::ELEM_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat_value = {1'b1, {(mmu_pkg::ELEM_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(mmu_pkg::ELEM_W-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      product_value <= sat_value;
      product_row   <= t3.row;
      product_col   <= t3.col;
      saturated     <= ovf;
      last_of_run   <= t3.run_end;
    end
  end

endmodule

`default_nettype wire

// File: rtl/matrix_multiply_unit.sv
// Top level: load sequencer, element stores and the multiply-accumulate pipeline.
// Loading takes one element beat per cycle, A then B, written straight into the stores.
// After B's last beat the single shared MAC runs R*C*K steps, one store read per cycle while
// the output is not stalled, and each dot product of K steps leaves as one result beat.
// Reset clears the control state and sets all dimensions to MAX_DIM; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_multiply_unit #(
  parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_write,
  input  wire logic [mmu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mmu_pkg::DIM_W-1:0]         cfg_data,
  // element input
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [mmu_pkg::ELEM_W-1:0] element_value,
  // product output
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [mmu_pkg::ELEM_W-1:0]      product_value,
  output logic [mmu_pkg::IDX_OUT_W-1:0]          product_row,
  output logic [mmu_pkg::IDX_OUT_W-1:0]          product_col,
  output logic                                   saturated,
  output logic                                   last_of_run
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [mmu_pkg::DIM_W-1:0] DIM_MAX = mmu_pkg::DIM_W'(MAX_DIM);

  mmu_pkg::state_t              state, state_next;
  logic [mmu_pkg::DIM_W-1:0]    rows_a, inner_dim, cols_b;
  logic [CNT_W-1:0]             load_count;
  logic [IDX_W-1:0]             r, c, k;
  logic                         cfg_hit;
  logic                         in_fire;
  logic [7:0]                   load_limit;
  logic                         load_done;
  logic                         a_we, b_we;
  logic                         computing;
  logic                         issue;
  logic                         stall;
  logic                         k_last, c_last, r_last;
  logic [AW-1:0]                a_raddr, b_raddr;
  logic [mmu_pkg::ELEM_W-1:0]   a_data, b_data;
  mmu_pkg::step_t               issue_tag;

  assign cfg_hit = cfg_write && (cfg_index == mmu_pkg::CFG_ROWS_A ||
                                 cfg_index == mmu_pkg::CFG_INNER_DIM ||
                                 cfg_index == mmu_pkg::CFG_COLS_B);
  assign in_fire = in_valid && in_ready;

  // dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_MAX;
      inner_dim <= DIM_MAX;
      cols_b    <= DIM_MAX;
    end else if (cfg_write) begin
      case (cfg_index)
        mmu_pkg::CFG_ROWS_A:    rows_a    <= mmu_pkg::clamp_dim(cfg_data, DIM_MAX);
        mmu_pkg::CFG_INNER_DIM: inner_dim <= mmu_pkg::clamp_dim(cfg_data, DIM_MAX);
        mmu_pkg::CFG_COLS_B:    cols_b    <= mmu_pkg::clamp_dim(cfg_data, DIM_MAX);
        default: ;
      endcase
    end
  end

  // element count of the matrix being loaded
  always_comb begin
    if (state == mmu_pkg::ST_LOAD_A) begin
      load_limit = 8'(rows_a) * 8'(inner_dim);
    end else begin
      load_limit = 8'(inner_dim) * 8'(cols_b);
    end
    load_done = in_fire && (8'(load_count) + 8'd1 == load_limit);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      load_count <= '0;
    end else if (load_done) begin
      load_count <= '0;
    end else if (in_fire) begin
      load_count <= load_count + CNT_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mmu_pkg::ST_LOAD_A:  if (load_done) state_next = mmu_pkg::ST_LOAD_B;
      mmu_pkg::ST_LOAD_B:  if (load_done) state_next = mmu_pkg::ST_COMPUTE;
      mmu_pkg::ST_COMPUTE: if (issue && r_last && c_last && k_last)
                             state_next = mmu_pkg::ST_LOAD_A;
      default:             state_next = mmu_pkg::ST_LOAD_A;
    endcase
    if (cfg_hit) state_next = mmu_pkg::ST_LOAD_A;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmu_pkg::ST_LOAD_A;
    end else begin
      state <= state_next;
    end
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    a_we      = 1'b0;
    b_we      = 1'b0;
    computing = 1'b0;
    case (state)
      mmu_pkg::ST_LOAD_A: begin
        in_ready = 1'b1;
        a_we     = in_fire;
      end
      mmu_pkg::ST_LOAD_B: begin
        in_ready = 1'b1;
        b_we     = in_fire;
      end
      mmu_pkg::ST_COMPUTE: begin
        computing = 1'b1;
      end
      default: ;
    endcase
  end

  // step counters: k innermost, then column, then row
  assign issue  = computing && !stall;
  assign k_last = (4'(k) + 4'd1 == inner_dim);
  assign c_last = (4'(c) + 4'd1 == cols_b);
  assign r_last = (4'(r) + 4'd1 == rows_a);

  always_ff @(posedge clk) begin
    if (rst || state != mmu_pkg::ST_COMPUTE) begin
      r <= '0;
      c <= '0;
      k <= '0;
    end else if (issue) begin
      if (!k_last) begin
        k <= k + IDX_W'(1);
      end else begin
        k <= '0;
        if (!c_last) begin
          c <= c + IDX_W'(1);
        end else begin
          c <= '0;
          r <= r + IDX_W'(1);
        end
      end
    end
  end

  // store read addresses
  assign a_raddr = AW'(8'(r) * 8'(inner_dim) + 8'(k));
  assign b_raddr = AW'(8'(k) * 8'(cols_b) + 8'(c));

  always_comb begin
    issue_tag.first   = (k == '0);
    issue_tag.last    = k_last;
    issue_tag.run_end = k_last && c_last && r_last;
    issue_tag.row     = mmu_pkg::IDX_OUT_W'(r);
    issue_tag.col     = mmu_pkg::IDX_OUT_W'(c);
  end

  mmu_mem #(.DEPTH(DEPTH), .AW(AW)) u_a_mem (
    .clk   (clk),
    .we    (a_we),
    .waddr (load_count[AW-1:0]),
    .wdata (element_value),
    .re    (issue),
    .raddr (a_raddr),
    .rdata (a_data)
  );

  mmu_mem #(.DEPTH(DEPTH), .AW(AW)) u_b_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (load_count[AW-1:0]),
    .wdata (element_value),
    .re    (issue),
    .raddr (b_raddr),
    .rdata (b_data)
  );

  mmu_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .issue         (issue),
    .issue_tag     (issue_tag),
    .a_data        (a_data),
    .b_data        (b_data),
    .stall         (stall),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .product_value (product_value),
    .product_row   (product_row),
    .product_col   (product_col),
    .saturated     (saturated),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

// File: rtl/mmu_check.sv
// Port-level checker of the matrix multiply unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_multiply_unit_macros.svh"

module mmu_check (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              cfg_write,
  input wire logic [mmu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [mmu_pkg::ELEM_W-1:0] product_value,
  input wire logic                              last_of_run
);

  // reset leaves the block waiting for A with no result beat pending
  `MMU_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, in_ready && !out_valid)

  // a register write restarts loading, so input is taken next cycle
  `MMU_ASSERT_NEXT(a_cfg_restart, clk, rst, cfg_write && cfg_index < mmu_pkg::CFG_NUM, in_ready)

  // a stalled result beat holds
  `MMU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(product_value) && $stable(last_of_run))

endmodule

bind matrix_multiply_unit mmu_check u_mmu_check (
  .clk           (clk),
  .rst           (rst),
  .cfg_write     (cfg_write),
  .cfg_index     (cfg_index),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .product_value (product_value),
  .last_of_run   (last_of_run)
);

`default_nettype wire

// File: tb/matrix_multiply_unit_tb.sv
// Self-checking testbench of the matrix multiply unit: random matrices against a Q16.16 predictor.
`timescale 1ns / 1ps

module matrix_multiply_unit_tb;
  import mmu_pkg::*;

  localparam int MAX_DIM     = MAX_DIM_DEFAULT;
  localparam int STORE_WORDS = MAX_DIM * MAX_DIM;
  localparam int SETTLE      = 8;     // cycles left after the last product before a write
  localparam int DRAIN       = 600;   // cycles waited before the final check
  localparam int LONG_HOLD   = 1500;  // receiver hold-off under back-pressure
  localparam int RANDOM_ELEMS = 160;

  localparam logic signed [ACC_W-1:0] Q_MAX = 67'sh0_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] Q_MIN = -67'sh0_8000_0000;

  typedef struct {
    logic signed [ELEM_W-1:0] value;
    logic [IDX_OUT_W-1:0]     row;
    logic [IDX_OUT_W-1:0]     col;
    logic                     sat;
    logic                     last;
  } product_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [DIM_W-1:0]         cfg_data  = '0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ELEM_W-1:0] product_value;
  logic [IDX_OUT_W-1:0]     product_row;
  logic [IDX_OUT_W-1:0]     product_col;
  logic                     saturated;
  logic                     last_of_run;

  matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .element_value(element_value),
    .out_valid(out_valid), .out_ready(out_ready), .product_value(product_value),
    .product_row(product_row), .product_col(product_col),
    .saturated(saturated), .last_of_run(last_of_run)
  );

  always #2 clk = ~clk;

  // stimulus and scoreboard state
  logic signed [ELEM_W-1:0] elements_q [$];
  product_t                 products_due [$];
  int elements_pushed = 0;
  int beats_taken     = 0;
  int mismatches      = 0;

  // knobs set by the sequencer at the falling edge
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit tx_hold     = 1'b0;
  int long_req    = 0;

  // receiver-side hold-off bookkeeping
  int long_seen = 0;
  int hold_left = 0;

  // predictor state
  logic signed [ELEM_W-1:0] a_mem [STORE_WORDS];
  logic signed [ELEM_W-1:0] b_mem [STORE_WORDS];
  int  dim_rows  = MAX_DIM;
  int  dim_inner = MAX_DIM;
  int  dim_cols  = MAX_DIM;
  int  load_pos  = 0;
  bit  on_b      = 1'b0;

  function automatic int clamp_dimension(input logic [DIM_W-1:0] v);
    int d;
    d = v;
    if (d == 0) d = 1;
    if (d > MAX_DIM) d = MAX_DIM;
    return d;
  endfunction

  // a register write always drops a partial load; an unknown index does nothing
  task automatic apply_dim_write(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    if (idx != CFG_NUM) begin
      case (idx)
        CFG_ROWS_A:    dim_rows  = clamp_dimension(v);
        CFG_INNER_DIM: dim_inner = clamp_dimension(v);
        default:       dim_cols  = clamp_dimension(v);
      endcase
      load_pos = 0;
      on_b     = 1'b0;
    end
  endtask

  // all R*C dot products, floored to Q16.16 and saturated
  task automatic form_products;
    int r, c, k;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] q;
    product_t p;
    for (r = 0; r < dim_rows; r++) begin
      for (c = 0; c < dim_cols; c++) begin
        acc = '0;
        for (k = 0; k < dim_inner; k++)
          acc = acc + a_mem[r * dim_inner + k] * b_mem[k * dim_cols + c];
        q = acc >>> FRAC_W;
        p.sat = 1'b0;
        if (q > Q_MAX) begin
          p.value = 32'sh7FFF_FFFF;
          p.sat   = 1'b1;
        end else if (q < Q_MIN) begin
          p.value = 32'sh8000_0000;
          p.sat   = 1'b1;
        end else begin
          p.value = q[ELEM_W-1:0];
        end
        p.row  = r[IDX_OUT_W-1:0];
        p.col  = c[IDX_OUT_W-1:0];
        p.last = (r == dim_rows - 1) && (c == dim_cols - 1);
        products_due.push_back(p);
      end
    end
  endtask

  task automatic take_element(input logic signed [ELEM_W-1:0] v);
    if (!on_b) begin
      a_mem[load_pos] = v;
      load_pos++;
      if (load_pos >= dim_rows * dim_inner) begin
        load_pos = 0;
        on_b     = 1'b1;
      end
    end else begin
      b_mem[load_pos] = v;
      load_pos++;
      if (load_pos >= dim_inner * dim_cols) begin
        load_pos = 0;
        on_b     = 1'b0;
        form_products();
      end
    end
  endtask

  // element driver: holds a beat until accepted, then maybe offers the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) begin
        take_element(element_value);
        beats_taken++;
      end
      if (!tx_hold && elements_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        element_value <= elements_q.pop_front();
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic check_beat;
    product_t e;
    if (products_due.size() == 0) begin
      $error("unexpected product beat: row %0d col %0d value %h",
             product_row, product_col, product_value);
      mismatches++;
    end else begin
      e = products_due.pop_front();
      if (product_value !== e.value) begin
        $error("product_value: expected %h, got %h", e.value, product_value);
        mismatches++;
      end
      if (product_row !== e.row) begin
        $error("product_row: expected %0d, got %0d", e.row, product_row);
        mismatches++;
      end
      if (product_col !== e.col) begin
        $error("product_col: expected %0d, got %0d", e.col, product_col);
        mismatches++;
      end
      if (saturated !== e.sat) begin
        $error("saturated: expected %0b, got %0b", e.sat, saturated);
        mismatches++;
      end
      if (last_of_run !== e.last) begin
        $error("last_of_run: expected %0b, got %0b", e.last, last_of_run);
        mismatches++;
      end
    end
  endtask

  // product monitor with random stalls and an occasional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_beat();
      if (long_req != long_seen) begin
        long_seen = long_req;
        hold_left = LONG_HOLD;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // sequencer helpers
  function automatic logic signed [ELEM_W-1:0] pick_element(input bit small_only);
    int sel;
    sel = small_only ? 99 : $urandom_range(99);
    if (sel < 30) return $urandom;
    if (sel < 40) begin
      case ($urandom_range(5))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh0000_0000;
        3:       return 32'shFFFF_FFFF;
        4:       return 32'sh0001_0000;
        default: return 32'shFFFF_0000;
      endcase
    end
    return $signed(32'($urandom_range(0, 262143))) - 32'sd131072;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim;
    int sel;
    sel = $urandom_range(99);
    if (sel < 6)  return 4'd0;
    if (sel < 12) return 4'($urandom_range(9, 15));
    if (sel < 18) return 4'd8;
    if (sel < 33) return 4'($urandom_range(5, 7));
    return 4'($urandom_range(1, 4));
  endfunction

  function automatic int pair_length;
    return dim_rows * dim_inner + dim_inner * dim_cols;
  endfunction

  task automatic push_value(input logic signed [ELEM_W-1:0] v);
    elements_q.push_back(v);
    elements_pushed++;
  endtask

  task automatic push_elements(input int n, input bit small_only);
    repeat (n) push_value(pick_element(small_only));
  endtask

  // block idle: nothing queued, nothing offered, nothing owed
  task automatic wait_idle;
    do @(negedge clk);
    while (elements_q.size() != 0 || in_valid || products_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    apply_dim_write(idx, v);
  endtask

  task automatic release_cfg;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
                          input logic [DIM_W-1:0] c);
    write_reg(CFG_ROWS_A, r);
    write_reg(CFG_INNER_DIM, k);
    write_reg(CFG_COLS_B, c);
    release_cfg();
  endtask

  // run limit
  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // sequencer
  initial begin
    int phase;
    int pairs;
    int start;
    int full;
    bit small_only;
    int tx_mode [4] = '{0, 72, 0, 36};
    int rx_mode [4] = '{0, 0, 72, 36};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // scalar products: saturation both ways and flooring of negatives
    set_dims(4'd1, 4'd1, 4'd1);
    push_value(32'sh7FFF_FFFF); push_value(32'sh7FFF_FFFF);
    push_value(32'sh8000_0000); push_value(32'sh8000_0000);
    push_value(32'sh8000_0000); push_value(32'sh7FFF_FFFF);
    push_value(32'shFFFF_FFFF); push_value(32'sh0000_0001);
    push_value(32'sh0001_0000); push_value(32'shFFFF_0000);

    // a write to the unused index leaves a half-done load intact
    push_value(pick_element(1'b0));
    wait_idle();
    write_reg(CFG_NUM, 4'd5);
    release_cfg();
    push_value(pick_element(1'b0));

    // a real write drops the half-done load; zero and oversize dims clamp
    push_value(pick_element(1'b0));
    wait_idle();
    set_dims(4'd15, 4'd1, 4'd0);
    push_elements(pair_length(), 1'b0);
    wait_idle();

    // back-pressure: receiver holds off while the sender keeps offering
    set_dims(4'd2, 4'd3, 4'd2);
    long_req++;
    repeat (5) push_elements(pair_length(), $urandom_range(1));
    wait_idle();

    // sender waits for every product of the previous run
    set_dims(4'd3, 4'd2, 4'd3);
    push_elements(pair_length(), 1'b1);
    do @(negedge clk); while (beats_taken != elements_pushed);
    tx_hold = 1'b1;
    push_elements(pair_length(), 1'b0);
    do @(negedge clk); while (products_due.size() != 0);
    repeat (SETTLE) @(negedge clk);
    tx_hold = 1'b0;
    wait_idle();

    // one full-size product
    set_dims(4'd8, 4'd8, 4'd8);
    push_elements(pair_length(), 1'b1);
    wait_idle();

    // random runs, cycling through the idling modes
    start = elements_pushed;
    phase = 0;
    while (elements_pushed - start < RANDOM_ELEMS) begin
      tx_idle_pct = tx_mode[phase % 4];
      rx_idle_pct = rx_mode[phase % 4];
      wait_idle();
      if ($urandom_range(5) == 0) begin
        write_reg(CFG_NUM, 4'($urandom_range(15)));
        release_cfg();
      end
      set_dims(pick_dim(), pick_dim(), pick_dim());
      full  = pair_length();
      pairs = (full > 64) ? 1 : $urandom_range(1, 4);
      repeat (pairs) begin
        small_only = $urandom_range(1);
        push_elements(full, small_only);
      end
      // now and then a broken sequence that the next write throws away
      if ($urandom_range(5) == 0)
        push_elements((full > 2) ? $urandom_range(1, full - 1) : 1, 1'b0);
      phase++;
    end

    // drain and settle
    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (products_due.size() != 0) begin
      $error("%0d expected products never arrived", products_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
